// ----- src/utq_pkg.sv -----
// Shared types, constants and the query-code encoder function for the
// UTF-8 to query code encoder. No dependencies.
package utq_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int RUN_MAX = 5;
   localparam int LEN_W   = 3;

   localparam logic [BYTE_W-1:0] CODE_ZERO     = 8'hE0;
   localparam logic [BYTE_W-1:0] CODE_LOW_ZERO = 8'hE1;
   localparam logic [BYTE_W-1:0] CODE_LONG     = 8'hE0;
   localparam logic [BYTE_W-1:0] HIGH_OFFSET   = 8'h40;
   localparam logic [BYTE_W-1:0] GROUP_MARK    = 8'h80;
   localparam logic [CP_W-1:0]   ASCII_LIMIT   = 21'h00080;
   localparam logic [CP_W-1:0]   PAIR_LOW      = 21'h04000;
   localparam logic [CP_W-1:0]   PAIR_HIGH     = 21'h0A000;
   localparam logic [CP_W-1:0]   THREE_LIMIT   = 21'h00800;
   localparam logic [CP_W-1:0]   FOUR_LIMIT    = 21'h40000;

   // queue write side, from the decoder
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] code_point;
   } q_push_type;

   // queue read side, to the encoder
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] code_point;
   } q_head_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]               len;
   } run_type;

   function automatic run_type encode_point(input logic [CP_W-1:0] v);
      run_type          r;
      logic [CP_W+2:0]  x;
      logic [6:0]       g3, g2, g1, g0;
      r.bytes = '0;
      r.len   = LEN_W'(1);
      x  = {v, 3'b000};
      g3 = {4'b0000, x[23:21]};
      g2 = x[20:14];
      g1 = x[13:7];
      g0 = x[6:0];
      if (v < ASCII_LIMIT) begin
         r.bytes[0] = (v == '0) ? CODE_ZERO : v[7:0];
         r.len      = LEN_W'(1);
      end else if (v >= PAIR_LOW && v < PAIR_HIGH) begin
         r.len = LEN_W'(2);
         if (v[7:0] == 8'h00) begin
            r.bytes[0] = CODE_LOW_ZERO;
            r.bytes[1] = v[15:8] + HIGH_OFFSET;
         end else begin
            r.bytes[0] = v[15:8] + HIGH_OFFSET;
            r.bytes[1] = v[7:0];
         end
      end else if (v >= FOUR_LIMIT) begin
         r.len      = LEN_W'(5);
         r.bytes[0] = CODE_LONG | 8'd4;
         r.bytes[1] = GROUP_MARK | {1'b0, g3};
         r.bytes[2] = GROUP_MARK | {1'b0, g2};
         r.bytes[3] = GROUP_MARK | {1'b0, g1};
         r.bytes[4] = GROUP_MARK | {1'b0, g0};
      end else if (v >= THREE_LIMIT) begin
         r.len      = LEN_W'(4);
         r.bytes[0] = CODE_LONG | 8'd3;
         r.bytes[1] = GROUP_MARK | {1'b0, g2};
         r.bytes[2] = GROUP_MARK | {1'b0, g1};
         r.bytes[3] = GROUP_MARK | {1'b0, g0};
      end else begin
         r.len      = LEN_W'(3);
         r.bytes[0] = CODE_LONG | 8'd2;
         r.bytes[1] = GROUP_MARK | {1'b0, g1};
         r.bytes[2] = GROUP_MARK | {1'b0, g0};
      end
      return r;
   endfunction

endpackage

// ----- src/utq_req_if.sv -----
// Request channel: one raw UTF-8 byte and its end-of-text flag.
// Depends on utq_pkg.
interface utq_req_if import utq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              text_end;

   modport source (output valid, output in_byte, output text_end, input ready);
   modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- src/utq_rsp_if.sv -----
// Response channel: one encoded query byte and its end-of-run mark.
// Depends on utq_pkg.
interface utq_rsp_if import utq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- src/utq_front.sv -----
// Decoder front: accepts UTF-8 request bytes, assembles code points and
// pushes each completed one into the queue. Depends on utq_pkg, utq_req_if.
module utq_front import utq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   utq_req_if.sink    req_chan,
   input  logic       q_full,
   output q_push_type q_push
);

   logic [CP_W-1:0] acc_ff, acc_in;
   logic [1:0]      pend_ff, pend_in;
   logic            fire;
   logic [7:0]      b;

   assign req_chan.ready = !q_full;
   assign fire = req_chan.valid && req_chan.ready;
   assign b    = req_chan.in_byte;

   always_comb begin
      acc_in            = acc_ff;
      pend_in           = pend_ff;
      q_push.valid      = 1'b0;
      q_push.code_point = '0;
      if (fire) begin
         if (pend_ff == 2'd0) begin
            case (b) inside
               [8'h00:8'h7F]: begin
                  q_push.valid      = 1'b1;
                  q_push.code_point = CP_W'(b);
               end
               [8'hC0:8'hDF]: begin
                  acc_in  = CP_W'(b[4:0]);
                  pend_in = 2'd1;
               end
               [8'hE0:8'hEF]: begin
                  acc_in  = CP_W'(b[3:0]);
                  pend_in = 2'd2;
               end
               default: begin
                  acc_in  = CP_W'(b[2:0]);
                  pend_in = 2'd3;
               end
            endcase
         end else begin
            pend_in = pend_ff - 2'd1;
            if (pend_in == 2'd0) begin
               q_push.valid      = 1'b1;
               q_push.code_point = {acc_ff[CP_W-7:0], b[5:0]};
               acc_in            = '0;
            end else begin
               acc_in = {acc_ff[CP_W-7:0], b[5:0]};
            end
         end
         // drop a character cut short by the end of the text
         if (req_chan.text_end && pend_in != 2'd0) begin
            acc_in  = '0;
            pend_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 2'd0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ----- src/utq_queue.sv -----
// Short code point queue between decoder and encoder.
// Depends on utq_pkg.
module utq_queue import utq_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  q_push_type q_push,
   input  logic       q_pop,
   output logic       q_full,
   output q_head_type q_head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CP_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign q_full            = (count_ff == CW'(DEPTH));
   assign q_head.valid      = (count_ff != '0);
   assign q_head.code_point = mem_ff[rd_ptr_ff];
   assign do_push           = q_push.valid && !q_full;
   assign do_pop            = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.code_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/utq_back.sv -----
// Encoder back: takes code points from the queue, forms the query-code run
// and sends it one byte per response. Depends on utq_pkg, utq_rsp_if.
module utq_back import utq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_head_type q_head,
   output logic       q_pop,
   utq_rsp_if.source  rsp_chan
);

   run_type          run_ff, run_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             last, fire, load;

   assign last  = (idx_ff == run_ff.len - LEN_W'(1));
   assign fire  = rsp_chan.valid && rsp_chan.ready;
   assign load  = q_head.valid && (!busy_ff || (fire && last));
   assign q_pop = load;

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.last_of_run = last;

   always_comb begin
      case (idx_ff)
         3'd0:    rsp_chan.out_byte = run_ff.bytes[0];
         3'd1:    rsp_chan.out_byte = run_ff.bytes[1];
         3'd2:    rsp_chan.out_byte = run_ff.bytes[2];
         3'd3:    rsp_chan.out_byte = run_ff.bytes[3];
         3'd4:    rsp_chan.out_byte = run_ff.bytes[4];
         default: rsp_chan.out_byte = run_ff.bytes[0];
      endcase
   end

   always_comb begin
      run_in  = run_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         run_in  = encode_point(q_head.code_point);
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- src/utf8_to_octagram_query_encoder_unit.sv -----
// Top level of the UTF-8 to query code encoder: decoder front, code point
// queue and encoder back. Depends on utq_pkg, utq_req_if, utq_rsp_if.
//
// Usage:
//  - req_chan carries one UTF-8 byte per request (in_byte) and text_end,
//    set on the last byte of a text. A character still incomplete after
//    that byte is dropped without output.
//  - rsp_chan carries one encoded byte per response; last_of_run marks the
//    final byte of each character's run (one to five bytes).
//  - Both channels are valid/ready; a transfer happens when both are high.
//  - Throughput: one request per cycle while the queue has room; the back
//    sends one response per cycle while the receiver is ready, so
//    characters that encode to several bytes drain at one byte a cycle
//    and the queue absorbs the difference. A completed character enters
//    the queue on its last byte; the back then loads it into run_ff.
//  - When the receiver stalls, the current byte holds on rsp_chan, the
//    queue fills (QUEUE_DEPTH code points) and then req_chan.ready drops.
//  - Reset (synchronous, active high) empties the queue, clears any partial
//    character and drops the run in flight.
module utf8_to_octagram_query_encoder_unit import utq_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   utq_req_if.sink   req_chan,
   utq_rsp_if.source rsp_chan
);

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   // decode bytes into code points
   utq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   // decouple decoding from the byte-serial encoder
   utq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // encode and send one byte per response
   utq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
